FILE: rtl/analog_ladder_encoder_decoder_assert.svh
// -----------------------------------------------------------------------------
// analog_ladder_encoder_decoder_assert
// assertion macros used by the ladder encoder decoder top module
// -----------------------------------------------------------------------------
`ifndef ANALOG_LADDER_ENCODER_DECODER_ASSERT_SVH
`define ANALOG_LADDER_ENCODER_DECODER_ASSERT_SVH

// checked on every clock edge outside reset
`define ALE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ALE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/ale_pkg.sv
// -----------------------------------------------------------------------------
// ale_pkg
// types and constants of the analog ladder encoder decoder
// -----------------------------------------------------------------------------
package ale_pkg;

   // adc sample and threshold width
   typedef logic [9:0]  level_type;
   typedef logic [31:0] time_type;
   typedef logic [1:0]  state_type;
   typedef logic [1:0]  event_type;
   typedef logic [2:0]  csr_index_type;

   // classified ladder states
   localparam state_type ST_NONE  = 2'd0;
   localparam state_type ST_PRESS = 2'd1;
   localparam state_type ST_CW    = 2'd2;
   localparam state_type ST_CCW   = 2'd3;

   // event codes on the result channel
   localparam event_type EV_NONE  = 2'd0;
   localparam event_type EV_PRESS = 2'd1;
   localparam event_type EV_CW    = 2'd2;
   localparam event_type EV_CCW   = 2'd3;

   // register indexes
   localparam csr_index_type REG_IDLE   = 3'd0;
   localparam csr_index_type REG_PRESS  = 3'd1;
   localparam csr_index_type REG_CW     = 3'd2;
   localparam csr_index_type REG_CCW    = 3'd3;
   localparam csr_index_type REG_WINDOW = 3'd4;

   // register reset values
   localparam level_type IDLE_RESET   = 10'd1000;
   localparam level_type PRESS_RESET  = 10'd100;
   localparam level_type CW_RESET     = 10'd400;
   localparam level_type CCW_RESET    = 10'd700;
   localparam level_type WINDOW_RESET = 10'd50;

   // a press is reported only when it lasts longer than this, in ms
   localparam time_type MIN_PRESS_MS = 32'd10;

   typedef struct packed {
      level_type idle_level;
      level_type press_level;
      level_type cw_level;
      level_type ccw_level;
      level_type window_half;
   } cfg_type;

   typedef struct packed {
      event_type event_res;
      time_type  press_duration;
      logic      act_load;
   } evt_type;

endpackage

FILE: rtl/analog_ladder_encoder_decoder.sv
// -----------------------------------------------------------------------------
// analog_ladder_encoder_decoder
// decodes adc samples of a resistor ladder rotary encoder with push button
// -----------------------------------------------------------------------------
// req channel: one item per transfer, tdata carries the 10-bit sample and the
//    32-bit millisecond timestamp.
// rsp channel: one result per request, tuser carries the event code (none,
//    press released, clockwise, counter-clockwise), tdata the press duration
//    and the is_pressed flag.
// csr channel: register writes by index, always ready; write only while no
//    request is in flight.
// path: a request is held in the input register, then its result in the
//    result register, which drives rsp.
// throughput: one request per cycle while rsp does not stall; the step is the
//    compares and one 32-bit subtract between the input register and the result register.
// reset: thresholds return to their defaults, the ladder state to none and
//    the activity timestamp to zero; both pipeline registers empty.
// stall: while rsp_tready is low the result register holds; one further
//    request is taken into the input register, then req_tready drops.
// -----------------------------------------------------------------------------
`include "analog_ladder_encoder_decoder_assert.svh"

module analog_ladder_encoder_decoder (
   input  logic                      clock,
   input  logic                      reset,
   // request stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [47:0]               req_tdata,   // sample[9:0], time_ms[41:10], zero pad
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,   // press_duration[31:0], is_pressed[32], pad
   output logic [1:0]                rsp_tuser,   // event_res[1:0]
   // register write port
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  ale_pkg::csr_index_type    csr_index,
   input  ale_pkg::level_type        csr_data
);
   import ale_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      s1_valid_ff, s1_valid_in;
   level_type s1_sample_ff, s1_sample_in;
   time_type  s1_time_ff, s1_time_in;
   logic      out_valid_ff, out_valid_in;
   event_type out_event_ff, out_event_in;
   time_type  out_dur_ff, out_dur_in;
   logic      out_press_ff, out_press_in;
   state_type state_ff, state_in;
   time_type  act_ff, act_in;

   logic      advance;
   state_type next_state;
   evt_type   evt;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_IDLE:   cfg_in.idle_level  = csr_data;
            REG_PRESS:  cfg_in.press_level = csr_data;
            REG_CW:     cfg_in.cw_level    = csr_data;
            REG_CCW:    cfg_in.ccw_level   = csr_data;
            REG_WINDOW: cfg_in.window_half = csr_data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline control
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // input register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_time_in   = s1_time_ff;
      if (req_tready) begin
         s1_valid_in  = req_tvalid;
         s1_sample_in = req_tdata[9:0];
         s1_time_in   = req_tdata[41:10];
      end
   end

   // classification and event logic
   ale_classify u_classify (
      .cfg        (cfg_ff),
      .sample     (s1_sample_ff),
      .state      (state_ff),
      .next_state (next_state)
   );

   ale_event u_event (
      .prev_state    (state_ff),
      .next_state    (next_state),
      .time_ms       (s1_time_ff),
      .activity_time (act_ff),
      .evt           (evt)
   );

   // state and result register
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_event_in = out_event_ff;
      out_dur_in   = out_dur_ff;
      out_press_in = out_press_ff;
      if (advance) begin
         state_in     = next_state;
         out_valid_in = 1'b1;
         out_event_in = evt.event_res;
         out_dur_in   = evt.press_duration;
         out_press_in = (next_state == ST_PRESS);
         if (evt.act_load) begin
            act_in = s1_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_level  <= IDLE_RESET;
         cfg_ff.press_level <= PRESS_RESET;
         cfg_ff.cw_level    <= CW_RESET;
         cfg_ff.ccw_level   <= CCW_RESET;
         cfg_ff.window_half <= WINDOW_RESET;
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff           <= ST_NONE;
         act_ff             <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         act_ff       <= act_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      s1_time_ff   <= s1_time_in;
      out_event_ff <= out_event_in;
      out_dur_ff   <= out_dur_in;
      out_press_ff <= out_press_in;
   end

   // result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_event_ff;
   assign rsp_tdata  = {7'd0, out_press_ff, out_dur_ff};

   // checks
   `ALE_ASSERT(a_press_dur_min,
      rsp_tvalid && rsp_tuser == EV_PRESS |-> out_dur_ff > MIN_PRESS_MS,
      "reported press not longer than minimum")
   `ALE_ASSERT(a_dur_zero,
      rsp_tvalid && rsp_tuser != EV_PRESS |-> out_dur_ff == '0,
      "duration set without press event")
   `ALE_ASSERT(a_event_not_pressed,
      rsp_tvalid && rsp_tuser != EV_NONE |-> !out_press_ff,
      "event reported while button held")
   `ALE_ASSERT(a_act_on_exit,
      advance && state_ff == ST_NONE && next_state != ST_NONE |=> act_ff == $past(s1_time_ff),
      "activity time not stamped on exit from none")
   `ALE_ASSERT_ALWAYS(a_reset_state,
      reset |=> state_ff == ST_NONE && !rsp_tvalid,
      "state not cleared by reset")

endmodule

FILE: rtl/ale_classify.sv
// -----------------------------------------------------------------------------
// ale_classify
// maps one adc sample and the current state to the next ladder state
// -----------------------------------------------------------------------------
module ale_classify (
   input  ale_pkg::cfg_type   cfg,
   input  ale_pkg::level_type sample,
   input  ale_pkg::state_type state,
   output ale_pkg::state_type next_state
);
   import ale_pkg::*;

   logic       above_idle;
   logic       below_press;
   logic       in_cw;
   logic       in_ccw;
   logic [10:0] s_plus_h;
   logic [10:0] cw_plus_h;
   logic [10:0] ccw_plus_h;

   // open window test, s > c - h rewritten as s + h > c to stay unsigned
   assign s_plus_h   = {1'b0, sample} + {1'b0, cfg.window_half};
   assign cw_plus_h  = {1'b0, cfg.cw_level} + {1'b0, cfg.window_half};
   assign ccw_plus_h = {1'b0, cfg.ccw_level} + {1'b0, cfg.window_half};

   assign above_idle  = sample > cfg.idle_level;
   assign below_press = sample < cfg.press_level;
   assign in_cw  = (s_plus_h > {1'b0, cfg.cw_level}) && ({1'b0, sample} < cw_plus_h);
   assign in_ccw = (s_plus_h > {1'b0, cfg.ccw_level}) && ({1'b0, sample} < ccw_plus_h);

   // priority: idle, then press, then clockwise, then counter-clockwise
   always_comb begin
      next_state = state;
      if (above_idle) begin
         next_state = ST_NONE;
      end else if (state == ST_NONE) begin
         if (below_press) begin
            next_state = ST_PRESS;
         end else if (in_cw) begin
            next_state = ST_CW;
         end else if (in_ccw) begin
            next_state = ST_CCW;
         end
      end
   end

endmodule

FILE: rtl/ale_event.sv
// -----------------------------------------------------------------------------
// ale_event
// derives the event code, press duration and activity-time load from a state transition
// -----------------------------------------------------------------------------
module ale_event (
   input  ale_pkg::state_type prev_state,
   input  ale_pkg::state_type next_state,
   input  ale_pkg::time_type  time_ms,
   input  ale_pkg::time_type  activity_time,
   output ale_pkg::evt_type   evt
);
   import ale_pkg::*;

   time_type held;

   // modulo 2^32 hold time
   assign held = time_ms - activity_time;

   always_comb begin
      evt.event_res      = EV_NONE;
      evt.press_duration = '0;
      evt.act_load       = 1'b0;
      if (next_state == ST_NONE) begin
         // return to none; a press event only on release of the button
         if (prev_state == ST_PRESS && held > MIN_PRESS_MS) begin
            evt.event_res      = EV_PRESS;
            evt.press_duration = held;
         end
      end else if (prev_state == ST_NONE) begin
         // leaving none stamps the activity time
         evt.act_load = 1'b1;
         case (next_state)
            ST_CW:   evt.event_res = EV_CW;
            ST_CCW:  evt.event_res = EV_CCW;
            default: evt.event_res = EV_NONE;
         endcase
      end
   end

endmodule

FILE: tb/sv/analog_ladder_encoder_decoder_tb.sv
// -----------------------------------------------------------------------------
// analog_ladder_encoder_decoder_tb
// self-checking bench for the resistor ladder encoder decoder: a directed set
// of samples at default thresholds, then phases of press, rotation and noise
// sequences under several threshold settings, with random idling on both
// streams and one long result-side hold-off; every result is predicted and
// compared in order
// -----------------------------------------------------------------------------
module analog_ladder_encoder_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ale_pkg::*;

   localparam int LEVEL_MAX = 2 ** $bits(level_type) - 1;

   // one predicted result
   typedef struct {
      event_type ev;
      time_type  dur;
      logic      pressed;
   } ladder_event_type;

   // tracks thresholds and ladder state, predicts and checks events
   class ladder_event_checker;
      level_type        idle_lvl, press_lvl, cw_lvl, ccw_lvl, win_half;
      state_type        cur_state, last_state;
      time_type         press_start;
      ladder_event_type expected_events[$];
      int unsigned      errors;

      function new();
         idle_lvl    = IDLE_RESET;
         press_lvl   = PRESS_RESET;
         cw_lvl      = CW_RESET;
         ccw_lvl     = CCW_RESET;
         win_half    = WINDOW_RESET;
         cur_state   = ST_NONE;
         last_state  = ST_NONE;
         press_start = '0;
         errors      = 0;
      endfunction

      function void write_reg(csr_index_type idx, level_type val);
         case (idx)
            REG_IDLE:   idle_lvl  = val;
            REG_PRESS:  press_lvl = val;
            REG_CW:     cw_lvl    = val;
            REG_CCW:    ccw_lvl   = val;
            REG_WINDOW: win_half  = val;
            default: ;
         endcase
      endfunction

      // open window, compared signed so the lower edge may go below zero
      function bit within_window(level_type smp, level_type centre);
         int s, c, h;
         s = int'(smp);
         c = int'(centre);
         h = int'(win_half);
         return (s > c - h) && (s < c + h);
      endfunction

      function void note_sample(level_type smp, time_type now);
         ladder_event_type r;
         time_type         held;
         r.ev = EV_NONE;
         r.dur = '0;
         // classify
         if (smp > idle_lvl) begin
            cur_state = ST_NONE;
         end else if (cur_state == ST_NONE) begin
            if (smp < press_lvl) cur_state = ST_PRESS;
            else if (within_window(smp, cw_lvl)) cur_state = ST_CW;
            else if (within_window(smp, ccw_lvl)) cur_state = ST_CCW;
         end
         // transitions
         if (cur_state == ST_NONE) begin
            if (last_state == ST_PRESS) begin
               held = now - press_start;
               if (held > MIN_PRESS_MS) begin
                  r.ev = EV_PRESS;
                  r.dur = held;
               end
            end
         end else if (last_state == ST_NONE) begin
            press_start = now;
            if (cur_state == ST_CW) r.ev = EV_CW;
            else if (cur_state == ST_CCW) r.ev = EV_CCW;
         end
         last_state = cur_state;
         r.pressed = (cur_state == ST_PRESS);
         expected_events.push_back(r);
      endfunction

      function void flag(string msg);
         if (errors < 10) $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endfunction

      function void check_event(event_type ev, time_type dur, logic pressed);
         ladder_event_type e;
         if (expected_events.size() == 0) begin
            flag($sformatf("unexpected result: event %0d duration %0d pressed %0b",
                           ev, dur, pressed));
            return;
         end
         e = expected_events.pop_front();
         if (ev !== e.ev || dur !== e.dur || pressed !== e.pressed)
            flag($sformatf("expected event %0d duration %0d pressed %0b, got %0d %0d %0b",
                           e.ev, e.dur, e.pressed, ev, dur, pressed));
      endfunction

      function int unsigned pending();
         return expected_events.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;   // sample[9:0], time_ms[41:10], zero pad
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;        // press_duration[31:0], is_pressed[32], pad
   logic [1:0]    rsp_tuser;        // event_res[1:0]
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_IDLE;
   level_type     csr_data = '0;

   ladder_event_checker sb = new();
   int unsigned         req_xfers = 0;
   int unsigned         items_sent = 0;
   int unsigned         hold_left = 0;
   bit                  hold_done = 1'b0;
   time_type            ms_now = '0;

   analog_ladder_encoder_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watch every transfer on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            sb.note_sample(req_tdata[9:0], req_tdata[41:10]);
            req_xfers <= req_xfers + 1;
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_event(rsp_tuser, rsp_tdata[31:0], rsp_tdata[32]);
      end
   end

   // result side: random stalls, a clean stretch, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_xfers >= 400) begin
         hold_done <= 1'b1;
         hold_left <= 79;
         rsp_tready <= 1'b0;
      end else if (req_xfers >= 600 && req_xfers < 700) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 19);
      end
   end

   // one sample transfer, preceded by a random gap outside the burst stretch
   task automatic send_sample(level_type smp, time_type t);
      int unsigned gap;
      gap = 0;
      if (!(items_sent >= 600 && items_sent < 700))
         while ($urandom_range(99) < 19) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {6'b0, t, smp};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic csr_write(csr_index_type idx, level_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // drain the pipeline, then load a new threshold set
   task automatic reconfigure(level_type idle, level_type press, level_type cw,
                              level_type ccw, level_type win, bit stray);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_IDLE, idle);
      csr_write(REG_PRESS, press);
      csr_write(REG_CW, cw);
      csr_write(REG_CCW, ccw);
      csr_write(REG_WINDOW, win);
      // an index past the last register must change nothing
      if (stray)
         csr_write(csr_index_type'($urandom_range(csr_index_type'('1), REG_WINDOW + 1)),
                   level_type'($urandom()));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic level_type pick_press();
      if (sb.press_lvl == 0) return level_type'($urandom());
      if ($urandom_range(3) == 0) return level_type'(sb.press_lvl - 1);
      return level_type'($urandom_range(sb.press_lvl - 1));
   endfunction

   function automatic level_type pick_release();
      if (sb.idle_lvl == LEVEL_MAX) return level_type'($urandom());
      if ($urandom_range(3) == 0) return level_type'(sb.idle_lvl + 1);
      return level_type'($urandom_range(LEVEL_MAX, sb.idle_lvl + 1));
   endfunction

   function automatic level_type pick_window(level_type centre);
      int lo, hi;
      lo = int'(centre) - int'(sb.win_half) + 1;
      hi = int'(centre) + int'(sb.win_half) - 1;
      if (lo < 0) lo = 0;
      if (hi > LEVEL_MAX) hi = LEVEL_MAX;
      if (lo > hi) return level_type'($urandom());
      case ($urandom_range(3))
         0: return level_type'(lo);
         1: return level_type'(hi);
         default: return level_type'($urandom_range(hi, lo));
      endcase
   endfunction

   // press/hold/release, rotations and noise with random content
   task automatic run_random(int unsigned count);
      int unsigned stop_at, kind, holds;
      time_type    t0, held;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            t0 = ms_now;
            send_sample(pick_press(), t0);
            holds = $urandom_range(3);
            repeat (holds)
               send_sample(level_type'($urandom_range(sb.idle_lvl)), t0 + $urandom_range(9));
            case ($urandom_range(3))
               0: held = $urandom_range(12, 8);
               1: held = $urandom_range(30);
               2: held = $urandom_range(5000);
               default: held = $urandom();
            endcase
            send_sample(pick_release(), t0 + held);
            ms_now = t0 + held + $urandom_range(50);
         end else if (kind < 75) begin
            send_sample(pick_window($urandom_range(1) ? sb.cw_lvl : sb.ccw_lvl), ms_now);
            if ($urandom_range(3) != 0)
               send_sample(level_type'($urandom_range(sb.idle_lvl)), ms_now + 1);
            send_sample(pick_release(), ms_now + 2);
            ms_now = ms_now + 3 + $urandom_range(20);
         end else begin
            send_sample(level_type'($urandom()),
                        ($urandom_range(3) == 0) ? time_type'($urandom()) : ms_now);
         end
      end
   endtask

   // overall time limit
   initial begin
      #1_000_000;
      $display("analog_ladder_encoder_decoder_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples at reset thresholds
      send_sample(10'd1023, 32'd0);
      send_sample(10'd0, 32'd100);            // press
      send_sample(10'd500, 32'd104);          // held
      send_sample(10'd1001, 32'd105);         // release too short
      send_sample(10'd99, 32'd200);           // just below the press level
      send_sample(10'd1000, 32'd205);         // at the idle level, still held
      send_sample(10'd1001, 32'd210);         // release exactly at the threshold
      send_sample(10'd50, 32'd300);
      send_sample(10'd1023, 32'd311);         // first reported duration
      send_sample(10'd10, 32'hFFFF_FFF0);
      send_sample(10'd1023, 32'h0000_0020);   // duration across timestamp wrap
      send_sample(10'd351, 32'd400);          // clockwise, lower edge inside
      send_sample(10'd100, 32'd401);          // rotation state holds
      send_sample(10'd1023, 32'd402);         // leaving rotation is silent
      send_sample(10'd350, 32'd410);          // on the window edge: nothing
      send_sample(10'd449, 32'd420);
      send_sample(10'd1001, 32'd421);
      send_sample(10'd700, 32'd430);          // counter-clockwise
      send_sample(10'd1023, 32'd431);
      send_sample(10'd100, 32'd440);          // at the press level: nothing
      send_sample(10'd749, 32'd450);
      send_sample(10'd1023, 32'hFFFF_FFFF);
      ms_now = 32'd500;

      run_random(136);
      // widest windows, no press possible, nothing above idle
      reconfigure(10'd1023, 10'd0, 10'd0, 10'd1023, 10'd1023, 1'b0);
      run_random(136);
      // empty windows, everything above zero is idle
      reconfigure(10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 1'b0);
      run_random(136);
      // press and both windows overlap
      reconfigure(10'd900, 10'd200, 10'd150, 10'd250, 10'd100, 1'b1);
      run_random(136);
      reconfigure(level_type'($urandom_range(LEVEL_MAX, 500)),
                  level_type'($urandom_range(200)), level_type'($urandom_range(600)),
                  level_type'($urandom_range(800)), level_type'($urandom_range(200)), 1'b0);
      run_random(136);
      reconfigure(level_type'($urandom()), level_type'($urandom()), level_type'($urandom()),
                  level_type'($urandom()), level_type'($urandom()), 1'b1);
      run_random(136);
      reconfigure(IDLE_RESET, PRESS_RESET, CW_RESET, CCW_RESET, WINDOW_RESET, 1'b0);
      run_random(40);

      // drain and let any late result show
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("analog_ladder_encoder_decoder_tb: PASS");
      else
         $display("analog_ladder_encoder_decoder_tb: FAIL");
      $finish;
   end

endmodule
